/* rtl/gpd_pkg.sv */
// Package for the grouped priority dispatcher: sizes, register map and controller states.
// Used by every module under rtl; depends on nothing else.
package gpd_pkg;

  localparam int QueueDepthDef     = 16;
  localparam int MaxGroupsDef      = 4;
  localparam int MaxDevicesDef     = 4;
  localparam int PriorityLevelsDef = 4;

  localparam int FieldW = 5;

  localparam logic [1:0] RegQueueLimit = 2'd0;
  localparam logic [1:0] RegGroups     = 2'd1;
  localparam logic [1:0] RegDevices    = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StCount,
    StScan,
    StPick,
    StShift,
    StDone
  } gpd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic submit;
    logic dec_dev;
    logic scan_slot;
    logic take;
    logic shift_slot;
    logic next_dev;
    logic clr_scan;
    logic start_tick;
    logic finish;
  } gpd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dev_last;
    logic slot_last;
    logic dev_free;
    logic found;
    logic shift_last;
    logic dev_done;
  } gpd_sts_t;

endpackage

/* rtl/gpd_ctrl.sv */
// Controller state machine of the dispatcher: sequences count-down, scan and removal.
// Depends on gpd_pkg.
module gpd_ctrl
  import gpd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     req_type_i,
  input  logic     out_valid_i,
  input  gpd_sts_t sts_i,
  output gpd_cmd_t cmd_o
);

  gpd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        // The output register holds the last result; a new item waits until it is free.
        in_ready_o = !out_valid_i;
        if (in_valid_i && !out_valid_i) begin
          if (req_type_i) begin
            cmd_o.start_tick = 1'b1;
            state_d = StCount;
          end else begin
            cmd_o.submit = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StCount: begin
        cmd_o.dec_dev = 1'b1;
        if (sts_i.dev_last) begin
          cmd_o.clr_scan = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.dev_done) begin
          state_d = StDone;
        end else if (!sts_i.dev_free) begin
          cmd_o.next_dev = 1'b1;
        end else begin
          cmd_o.scan_slot = 1'b1;
          if (sts_i.slot_last) begin
            state_d = StPick;
          end
        end
      end
      StPick: begin
        if (sts_i.found) begin
          cmd_o.take = 1'b1;
          state_d = StShift;
        end else begin
          cmd_o.next_dev = 1'b1;
          state_d = StScan;
        end
      end
      StShift: begin
        cmd_o.shift_slot = 1'b1;
        if (sts_i.shift_last) begin
          cmd_o.next_dev = 1'b1;
          state_d = StScan;
        end
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* rtl/gpd_datapath.sv */
// Datapath of the dispatcher: slot queue, device counters, scan pointers and result register.
// Depends on gpd_pkg; driven by gpd_ctrl.
module gpd_datapath
  import gpd_pkg::*;
#(
  parameter int QueueDepth     = QueueDepthDef,
  parameter int MaxGroups      = MaxGroupsDef,
  parameter int MaxDevices     = MaxDevicesDef,
  parameter int PriorityLevels = PriorityLevelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpd_cmd_t          cmd_i,
  output gpd_sts_t          sts_o,
  input  logic [1:0]        app_group_i,
  input  logic [1:0]        app_priority_i,
  input  logic [7:0]        app_work_time_i,
  input  logic [4:0]        queue_limit_i,
  input  logic [2:0]        groups_in_use_i,
  input  logic [2:0]        devices_per_group_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              accepted_o,
  output logic [FieldW-1:0] queued_total_o,
  output logic [FieldW-1:0] busy_devices_o,
  output logic [FieldW-1:0] dispatched_o
);

  localparam int NumDevs = MaxGroups * MaxDevices;
  localparam int SlotW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW    = $clog2(QueueDepth + 1);
  localparam int DevW    = (NumDevs > 1) ? $clog2(NumDevs) : 1;
  localparam int DcW     = $clog2(NumDevs + 1);
  localparam int GrpW    = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;
  localparam int SubW    = (MaxDevices > 1) ? $clog2(MaxDevices) : 1;
  localparam int PriW    = $clog2(PriorityLevels);

  logic [1:0]      slot_group_q    [QueueDepth];
  logic [PriW-1:0] slot_priority_q [QueueDepth];
  logic [7:0]      slot_work_q     [QueueDepth];
  logic [NumDevs-1:0] dev_busy_q;
  logic [7:0]      dev_rem_q [NumDevs];
  logic [CntW-1:0] wait_q;
  logic [DcW-1:0]  busy_cnt_q;
  logic [DcW-1:0]  disp_q;

  logic [DevW-1:0]  dev_ptr_q;
  logic [GrpW-1:0]  grp_q;
  logic [SubW-1:0]  sub_q;
  logic [CntW-1:0]  slot_ptr_q;
  logic [SlotW-1:0] best_q;
  logic             found_q;
  logic             last_wrap_q;

  logic              out_valid_q;
  logic              accepted_q;
  logic [FieldW-1:0] queued_q, busy_q, dispd_q;

  // Clamped configuration.
  logic [CntW:0] limit;
  logic [3:0]    ngroups, ndevs;
  always_comb begin
    if (32'(queue_limit_i) > QueueDepth) limit = (CntW+1)'(QueueDepth);
    else limit = (CntW+1)'(queue_limit_i);
    if (groups_in_use_i == 3'd0) ngroups = 4'd1;
    else if (4'(groups_in_use_i) > 4'(MaxGroups)) ngroups = 4'(MaxGroups);
    else ngroups = 4'(groups_in_use_i);
    if (devices_per_group_i == 3'd0) ndevs = 4'd1;
    else if (4'(devices_per_group_i) > 4'(MaxDevices)) ndevs = 4'(MaxDevices);
    else ndevs = 4'(devices_per_group_i);
  end

  logic [DevW-1:0]  cur_dev;
  logic [SlotW-1:0] sp;
  logic             slot_match, slot_better;
  logic [7:0]       rem_dec;
  logic             submit_ok;
  always_comb begin
    cur_dev     = DevW'(32'(grp_q) * MaxDevices + 32'(sub_q));
    sp          = slot_ptr_q[SlotW-1:0];
    slot_match  = (slot_ptr_q < wait_q) && (32'(slot_group_q[sp]) == 32'(grp_q));
    slot_better = !found_q || (slot_priority_q[sp] > slot_priority_q[best_q]);
    rem_dec     = (dev_rem_q[dev_ptr_q] != 8'd0) ? dev_rem_q[dev_ptr_q] - 8'd1 : 8'd0;
    submit_ok   = ((CntW+1)'(wait_q) < limit) && ({1'b0, app_group_i} < ngroups[2:0]);
    sts_o.dev_last   = (32'(dev_ptr_q) == NumDevs - 1);
    sts_o.slot_last  = (32'(slot_ptr_q) >= QueueDepth - 1) || (slot_ptr_q + 1'b1 >= wait_q);
    sts_o.dev_free   = !dev_busy_q[cur_dev];
    sts_o.found      = found_q;
    sts_o.shift_last = (CntW'(best_q) + 1'b1 >= wait_q - 1'b1) || (wait_q <= CntW'(1));
    sts_o.dev_done   = (4'(grp_q) >= ngroups) || last_wrap_q;
  end

  // Slot storage is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.submit && submit_ok) begin
      slot_group_q[wait_q[SlotW-1:0]]    <= app_group_i;
      slot_priority_q[wait_q[SlotW-1:0]] <= PriW'(app_priority_i);
      slot_work_q[wait_q[SlotW-1:0]]     <=
          (app_work_time_i == 8'd0) ? 8'd1 : app_work_time_i;
    end
    if (cmd_i.shift_slot && (CntW'(best_q) + 1'b1 < wait_q)) begin
      slot_group_q[best_q]    <= slot_group_q[best_q + 1'b1];
      slot_priority_q[best_q] <= slot_priority_q[best_q + 1'b1];
      slot_work_q[best_q]     <= slot_work_q[best_q + 1'b1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_busy_q  <= '0;
      for (int i = 0; i < NumDevs; i++) dev_rem_q[i] <= 8'd0;
      wait_q      <= '0;
      busy_cnt_q  <= '0;
      disp_q      <= '0;
      dev_ptr_q   <= '0;
      grp_q       <= '0;
      sub_q       <= '0;
      slot_ptr_q  <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      queued_q    <= '0;
      busy_q      <= '0;
      dispd_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.submit) begin
        out_valid_q <= 1'b1;
        accepted_q  <= submit_ok;
        queued_q    <= FieldW'(wait_q + CntW'(submit_ok));
        busy_q      <= FieldW'(busy_cnt_q);
        dispd_q     <= '0;
        if (submit_ok) wait_q <= wait_q + 1'b1;
      end
      if (cmd_i.start_tick) begin
        dev_ptr_q <= '0;
        disp_q    <= '0;
      end
      if (cmd_i.dec_dev) begin
        if (dev_busy_q[dev_ptr_q]) begin
          dev_rem_q[dev_ptr_q] <= rem_dec;
          if (rem_dec == 8'd0) begin
            dev_busy_q[dev_ptr_q] <= 1'b0;
            busy_cnt_q <= busy_cnt_q - 1'b1;
          end
        end
        dev_ptr_q <= dev_ptr_q + 1'b1;
      end
      if (cmd_i.clr_scan) begin
        grp_q      <= '0;
        sub_q      <= '0;
        slot_ptr_q <= '0;
        found_q    <= 1'b0;
      end
      if (cmd_i.scan_slot) begin
        if (slot_match && slot_better) begin
          best_q  <= sp;
          found_q <= 1'b1;
        end
        slot_ptr_q <= slot_ptr_q + 1'b1;
      end
      if (cmd_i.take) begin
        dev_busy_q[cur_dev] <= 1'b1;
        dev_rem_q[cur_dev]  <= slot_work_q[best_q];
        busy_cnt_q <= busy_cnt_q + 1'b1;
        disp_q     <= disp_q + 1'b1;
      end
      if (cmd_i.shift_slot) begin
        if (sts_o.shift_last) begin
          wait_q <= wait_q - 1'b1;
        end else begin
          best_q <= best_q + 1'b1;
        end
      end
      if (cmd_i.next_dev) begin
        slot_ptr_q <= '0;
        found_q    <= 1'b0;
        if (4'(sub_q) + 4'd1 >= ndevs) begin
          sub_q <= '0;
          if (32'(grp_q) != MaxGroups - 1) grp_q <= grp_q + 1'b1;
        end else begin
          sub_q <= sub_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        accepted_q  <= 1'b0;
        queued_q    <= FieldW'(wait_q);
        busy_q      <= FieldW'(busy_cnt_q);
        dispd_q     <= FieldW'(disp_q);
      end
    end
  end

  // When the last group saturates the pointer, this flag ends the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_wrap_q <= 1'b0;
    end else if (cmd_i.clr_scan) begin
      last_wrap_q <= 1'b0;
    end else if (cmd_i.next_dev && (4'(sub_q) + 4'd1 >= ndevs)
                 && (32'(grp_q) == MaxGroups - 1)) begin
      last_wrap_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign queued_total_o = queued_q;
  assign busy_devices_o = busy_q;
  assign dispatched_o   = dispd_q;

endmodule

/* rtl/grouped_priority_dispatcher.sv */
// Top level of the grouped priority dispatcher: APB registers, controller and datapath.
// Depends on gpd_pkg, gpd_ctrl and gpd_datapath.
//
//   Channel   Signals                                       Direction
//   input     in_valid_i / in_ready_o, req_type_i, app_*_i  in
//   result    out_valid_o / out_ready_i, accepted_o, ...    out
//   config    psel/penable/pwrite/paddr/pwdata/prdata       APB
//
// A submit posts its result the cycle after it is taken. A tick counts down every device,
// then visits each active device in turn: a busy one is skipped, and for a free one the
// waiting slots of its group are scanned, the highest-priority match is picked and, on a
// dispatch, the slots behind it are shifted down; the result is posted last. How long
// a tick runs is set by the sequential scan of the single slot queue.
// Reset clears the queue, all devices and the registers to 16, 4, 4.
// A new item is taken only while the result register is empty.
module grouped_priority_dispatcher
  import gpd_pkg::*;
#(
  parameter int QueueDepth     = QueueDepthDef,
  parameter int MaxGroups      = MaxGroupsDef,
  parameter int MaxDevices     = MaxDevicesDef,
  parameter int PriorityLevels = PriorityLevelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [1:0]        app_group_i,
  input  logic [1:0]        app_priority_i,
  input  logic [7:0]        app_work_time_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              accepted_o,
  output logic [FieldW-1:0] queued_total_o,
  output logic [FieldW-1:0] busy_devices_o,
  output logic [FieldW-1:0] dispatched_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [4:0] queue_limit_q;
  logic [2:0] groups_q, devs_q;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_limit_q <= 5'd16;
      groups_q      <= 3'd4;
      devs_q        <= 3'd4;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        RegQueueLimit: queue_limit_q <= pwdata[4:0];
        RegGroups:     groups_q      <= pwdata[2:0];
        RegDevices:    devs_q        <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegQueueLimit: prdata = {27'd0, queue_limit_q};
      RegGroups:     prdata = {29'd0, groups_q};
      RegDevices:    prdata = {29'd0, devs_q};
      default:       prdata = 32'd0;
    endcase
  end

  gpd_cmd_t cmd;
  gpd_sts_t sts;

  gpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_i (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gpd_datapath #(
    .QueueDepth     (QueueDepth),
    .MaxGroups      (MaxGroups),
    .MaxDevices     (MaxDevices),
    .PriorityLevels (PriorityLevels)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .app_group_i         (app_group_i),
    .app_priority_i      (app_priority_i),
    .app_work_time_i     (app_work_time_i),
    .queue_limit_i       (queue_limit_q),
    .groups_in_use_i     (groups_q),
    .devices_per_group_i (devs_q),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .accepted_o          (accepted_o),
    .queued_total_o      (queued_total_o),
    .busy_devices_o      (busy_devices_o),
    .dispatched_o        (dispatched_o)
  );

endmodule

/* rtl/gpd_checker.sv */
// Port-level checker for the grouped priority dispatcher, bound to the top level.
// Depends on gpd_pkg.
module gpd_checker
  import gpd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              accepted_o,
  input logic [FieldW-1:0] queued_total_o,
  input logic [FieldW-1:0] dispatched_o
);

  // An item is never taken while a result is still waiting.
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken with result pending");

  // A result never reports both a queued job and a dispatch.
  a_acc_no_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (dispatched_o == '0)) else $error("accept with dispatch");

  // The waiting count never exceeds sixteen.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queued_total_o <= 5'd16)) else $error("queue count too large");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(queued_total_o)))
    else $error("result changed under stall");

endmodule

bind grouped_priority_dispatcher gpd_checker u_gpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .queued_total_o (queued_total_o),
  .dispatched_o   (dispatched_o)
);
